// ----- src/ipd_pkg.sv -----
// ipd_pkg: shared types and constants for the modem http response parser
// no dependencies
`default_nettype none
package ipd_pkg;

    typedef struct packed {
        logic       start_req;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic [7:0]  body_index;
        logic [3:0]  header_phase;
        logic [23:0] status_chars;
        logic [31:0] content_length;
        logic [23:0] discarded_count;
        logic [2:0]  outcome;
    } t_out;

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CLOSE   = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } t_frame_phase;

    localparam logic [2:0] OUT_RUN    = 3'd0;
    localparam logic [2:0] OUT_OK     = 3'd1;
    localparam logic [2:0] OUT_BAD    = 3'd2;
    localparam logic [2:0] OUT_TOKERR = 3'd3;
    localparam logic [2:0] OUT_EXTRA  = 3'd4;

    // classified byte handed from the framing part to the header walk
    typedef struct packed {
        logic       clear;     // start_req seen on this byte
        logic       line_clr;  // ':' ended a length field
        logic       walk;      // payload byte for the header walk
        logic [7:0] c;
        logic [2:0] outcome;   // framing outcome after this byte
    } t_cmd;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'h20;

    function automatic logic [7:0] tok_ipd(input logic [2:0] p);
        case (p)
            3'd0: tok_ipd = "+";
            3'd1: tok_ipd = "I";
            3'd2: tok_ipd = "P";
            3'd3: tok_ipd = "D";
            default: tok_ipd = ",";
        endcase
    endfunction

    function automatic logic [7:0] tok_close(input logic [2:0] p);
        case (p)
            3'd0: tok_close = "C";
            3'd1: tok_close = "L";
            3'd2: tok_close = "O";
            3'd3: tok_close = "S";
            default: tok_close = "E";
        endcase
    endfunction

    function automatic logic [7:0] key_http(input logic [1:0] p);
        case (p)
            2'd0: key_http = "H";
            2'd1: key_http = "T";
            2'd2: key_http = "T";
            default: key_http = "P";
        endcase
    endfunction

    function automatic logic [7:0] key_clen(input logic [3:0] p);
        logic [127:0] s;
        s = "Content-Length: ";
        key_clen = s[8'd127 - {p, 3'd0} -: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction

endpackage
`default_nettype wire

// ----- src/ipd_front.sv -----
// ipd_front: outer framing (token sync, length, payload count, close tail)
// depends on ipd_pkg
`default_nettype none
module ipd_front import ipd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_in  i_item,
    output t_cmd      o_cmd
);
    t_frame_phase r_ph, n_ph;
    logic [2:0]  r_tpos, n_tpos;
    logic [1:0]  r_flags, n_flags;
    logic [1:0]  r_tail, n_tail;
    logic [15:0] r_left, n_left;
    logic        r_dend, n_dend;
    logic [2:0]  r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_TOKEN; r_tpos <= '0; r_flags <= 2'b11; r_tail <= '0;
            r_left <= '0; r_dend <= 1'b0; r_out <= OUT_RUN;
        end else if (i_fire) begin
            r_ph <= n_ph; r_tpos <= n_tpos; r_flags <= n_flags; r_tail <= n_tail;
            r_left <= n_left; r_dend <= n_dend; r_out <= n_out;
        end
    end

    always_comb begin
        t_frame_phase ph;
        logic [2:0]  tp, p;
        logic [1:0]  fl, tl;
        logic [15:0] lf;
        logic        de;
        logic [2:0]  oc;
        logic [20:0] v;
        logic [7:0]  c;
        c = i_item.rx_byte;
        if (i_item.start_req) begin
            ph = PH_TOKEN; tp = '0; fl = 2'b11; tl = '0; lf = '0; de = 1'b0; oc = OUT_RUN;
        end else begin
            ph = r_ph; tp = r_tpos; fl = r_flags; tl = r_tail; lf = r_left; de = r_dend;
            oc = r_out;
        end
        o_cmd = '0;
        o_cmd.clear = i_item.start_req;
        o_cmd.c = c;
        v = '0;
        p = '0;
        case (ph)
            PH_TOKEN: begin
                if (!(tp == 3'd0 && (c == CH_CR || c == CH_LF))) begin
                    p = (tp < 3'd5) ? tp : 3'd4;
                    if (c != tok_ipd(p))   fl[0] = 1'b0;
                    if (c != tok_close(p)) fl[1] = 1'b0;
                    tp = p + 3'd1;
                    if (tp == 3'd5) begin
                        tp = '0;
                        if (fl[1]) begin
                            ph = PH_CLOSE; tl = 2'd3;
                        end else if (fl[0]) begin
                            ph = PH_LENGTH; lf = '0; de = 1'b0;
                        end else begin
                            ph = PH_ERROR; oc = OUT_TOKERR;
                        end
                        fl = 2'b11;
                    end
                end
            end
            PH_LENGTH: begin
                if (c == ":") begin
                    o_cmd.line_clr = 1'b1;
                    ph = (lf != '0) ? PH_PAYLOAD : PH_TOKEN;
                end else if (!de && is_digit(c)) begin
                    v = {lf, 3'd0} + {2'd0, lf, 1'b0} + {13'd0, c - 8'h30};
                    lf = (v > 21'd65535) ? 16'hFFFF : v[15:0];
                end else begin
                    de = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (lf != '0) lf = lf - 16'd1;
                o_cmd.walk = 1'b1;
                if (lf == '0) ph = PH_TOKEN;
            end
            PH_CLOSE: begin
                if (tl != '0) tl = tl - 2'd1;
                // status is known to the back part; it resolves ok versus bad
                if (tl == '0) begin
                    ph = PH_DONE; oc = OUT_OK;
                end
            end
            PH_DONE: oc = OUT_EXTRA;
            default: ;
        endcase
        o_cmd.outcome = oc;
        n_ph = ph; n_tpos = tp; n_flags = fl; n_tail = tl; n_left = lf; n_dend = de;
        n_out = oc;
    end
endmodule
`default_nettype wire

// ----- src/ipd_fifo.sv -----
// ipd_fifo: two-entry queue between framing and header walk
// depends on ipd_pkg
`default_nettype none
module ipd_fifo import ipd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_empty,
    input  wire logic i_rd,
    output t_cmd      o_data
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

// ----- src/ipd_walk.sv -----
// ipd_walk: http header walk, body capture and result register
// depends on ipd_pkg
`default_nettype none
module ipd_walk import ipd_pkg::*; #(
    parameter int BODY_BUF_SIZE = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_cmd i_cmd,
    output t_out      o_res
);
    localparam logic [8:0] BUF_N = 9'(BODY_BUF_SIZE);

    logic [3:0]  r_step, n_step;
    logic [8:0]  r_cnt, n_cnt;
    logic        r_km, n_km;
    logic        r_cr, n_cr;
    logic [23:0] r_st, n_st;
    logic        r_good, n_good;
    logic [31:0] r_len, n_len;
    logic        r_lend, n_lend;
    logic [23:0] r_drop, n_drop;
    t_out        n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0; r_cnt <= '0; r_km <= 1'b1; r_cr <= 1'b0; r_st <= '0;
            r_good <= 1'b0; r_len <= '0; r_lend <= 1'b0; r_drop <= '0;
        end else if (i_fire) begin
            r_step <= n_step; r_cnt <= n_cnt; r_km <= n_km; r_cr <= n_cr; r_st <= n_st;
            r_good <= n_good; r_len <= n_len; r_lend <= n_lend; r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) o_res <= n_res;
    end

    always_comb begin
        logic [3:0]  sp;
        logic [8:0]  cnt, lc;
        logic        km, cr, gd, le;
        logic [23:0] st, dr;
        logic [31:0] ln;
        logic [35:0] v;
        logic [7:0]  c;
        c = i_cmd.c;
        if (i_cmd.clear) begin
            sp = '0; lc = '0; km = 1'b1; cr = 1'b0; st = '0; gd = 1'b0; ln = '0;
            le = 1'b0; dr = '0;
        end else begin
            sp = r_step; lc = r_cnt; km = r_km; cr = r_cr; st = r_st; gd = r_good;
            ln = r_len; le = r_lend; dr = r_drop;
        end
        if (i_cmd.line_clr) lc = '0;
        n_res = '0;
        v = '0;
        cnt = lc;
        if (i_cmd.walk) begin
            cnt = (lc < 9'd511) ? lc + 9'd1 : 9'd511;
            case (sp)
                4'd0: begin
                    if (cnt <= 9'd4) begin
                        if (cnt == 9'd1) begin
                            km = (c == key_http(2'd0)); cr = (c == CH_CR);
                        end else begin
                            km = km && (c == key_http(2'(cnt - 9'd1)));
                        end
                        if (cnt == 9'd4 && km) begin
                            sp = 4'd1; cnt = '0;
                        end
                    end else if (dr != 24'hFFFFFF) dr = dr + 24'd1;
                end
                4'd1: if (c == CH_SP) begin
                    sp = 4'd2; cnt = '0;
                end
                4'd2: begin
                    case (cnt)
                        9'd0: st[7:0]   = c;
                        9'd1: st[23:16] = c;
                        9'd2: st[15:8]  = c;
                        9'd3: st[7:0]   = c;
                        default: ;
                    endcase
                    if (cnt == 9'd3) begin
                        if (st[23:16] == "1" || st[23:16] == "2" || st[23:16] == "3")
                            gd = 1'b1;
                        sp = 4'd3; cnt = '0;
                    end
                end
                4'd3: if (c == CH_LF) begin
                    sp = 4'd4; cnt = '0;
                end
                4'd4: begin
                    if (cnt > 9'd32 || c == CH_LF) begin
                        if (c == CH_LF) cnt = '0;
                    end else begin
                        if (cnt == 9'd1) begin
                            km = (c == key_clen(4'd0)); cr = (c == CH_CR);
                        end else begin
                            km = km && cnt <= 9'd16 && (c == key_clen(4'(cnt - 9'd1)));
                        end
                        if (cnt == 9'd16 && km) begin
                            sp = 4'd5; cnt = '0;
                        end
                    end
                end
                4'd5: begin
                    if (cnt <= 9'd32) begin
                        if (c == CH_LF) begin
                            sp = 4'd6; cnt = '0;
                        end else if (!le) begin
                            if (is_digit(c)) begin
                                v = {1'b0, ln, 3'd0} + {3'd0, ln, 1'b0}
                                    + {28'd0, c - 8'h30};
                                ln = (v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
                            end else le = 1'b1;
                        end
                    end else if (dr != 24'hFFFFFF) dr = dr + 24'd1;
                end
                4'd6: begin
                    if (cnt > 9'd32 || c == CH_LF) begin
                        if (c == CH_LF) begin
                            if (cnt <= 9'd32 && cr) sp = 4'd7;
                            cnt = '0;
                        end
                    end else if (cnt == 9'd1) cr = (c == CH_CR);
                end
                4'd7: begin
                    n_res.body_valid = 1'b1;
                    n_res.body_byte  = c;
                    n_res.body_index = 8'(cnt - 9'd1);
                    if (cnt == BUF_N) sp = 4'd8;
                end
                default: if (dr != 24'hFFFFFF) dr = dr + 24'd1;
            endcase
        end
        n_step = sp; n_cnt = cnt; n_km = km; n_cr = cr; n_st = st; n_good = gd;
        n_len = ln; n_lend = le; n_drop = dr;
        n_res.header_phase    = sp;
        n_res.status_chars    = st;
        n_res.content_length  = ln;
        n_res.discarded_count = dr;
        n_res.outcome = (i_cmd.outcome == OUT_OK && !gd) ? OUT_BAD : i_cmd.outcome;
    end
endmodule
`default_nettype wire

// ----- src/ipd_http_response_parser_unit.sv -----
// ipd_http_response_parser_unit: top level of the modem http response parser
// depends on ipd_pkg, ipd_front, ipd_fifo, ipd_walk
// usage:
//   input channel carries one received byte per transaction plus start_req,
//   which clears all parse state before that byte is handled.
//   output channel returns exactly one result per input byte: body byte and
//   index when a body byte is captured, plus header step, status characters,
//   content length, dropped byte count and outcome.
//   the framing front classifies each byte in the accept cycle and pushes it
//   into a two-entry queue; the header walk pops one entry a cycle into the
//   output register unless the receiver stalls. the result thus passes the
//   queue and then the output register; throughput is one byte per cycle
//   while the receiver does not stall.
//   when the receiver stalls, the result register holds, input is still
//   accepted until the two-entry queue is full, then o_stall rises.
//   reset (synchronous, active low) empties the queue and puts every parse
//   state at its start values; the block accepts bytes on the next cycle.
`default_nettype none
module ipd_http_response_parser_unit import ipd_pkg::*; #(
    parameter int BODY_BUF_SIZE = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);
    t_cmd w_cmd, q_cmd;
    logic q_full, q_empty, in_fire, q_pop;
    logic r_ovalid;

    assign o_stall = q_full;
    assign in_fire = i_valid && !q_full;
    assign q_pop   = !q_empty && (!r_ovalid || !i_stall);

    ipd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(in_fire), .i_item(i_data),
        .o_cmd(w_cmd)
    );

    ipd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(in_fire), .i_data(w_cmd),
        .o_full(q_full), .o_empty(q_empty), .i_rd(q_pop), .o_data(q_cmd)
    );

    ipd_walk #(.BODY_BUF_SIZE(BODY_BUF_SIZE)) u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(q_pop), .i_cmd(q_cmd),
        .o_res(o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (q_pop) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

// ----- src/ipd_checker.sv -----
// ipd_checker: port-level checks for the http response parser
// depends on ipd_pkg and ipd_http_response_parser_unit
`default_nettype none
module ipd_checker import ipd_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");
    a_outcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.outcome <= OUT_EXTRA)
        else $error("bad outcome code");
    a_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.body_valid |-> o_data.header_phase == 4'd7
            || o_data.header_phase == 4'd8)
        else $error("body byte outside body phase");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> ##1 o_valid)
        else $error("result missing after accept");
endmodule

bind ipd_http_response_parser_unit ipd_checker u_ipd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
`default_nettype wire
